[rtl/npba_pkg.sv]
// Package for the port block allocator: operation and status codes, shared types.
// Depends on nothing; used by every module of the block.
package npba_pkg;

    // Largest number of blocks the lists and the in-use map can hold.
    localparam int MAX_BLOCKS = 4096;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TICK    = 2'd2,
        OP_REBUILD = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_NOT_USED = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_ADDR_START = 3'd0,
        CFG_ADDR_COUNT = 3'd1,
        CFG_BPA        = 3'd2,
        CFG_PPB        = 3'd3,
        CFG_PORT_MIN   = 3'd4,
        CFG_TIMEOUT    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_op         op;
        logic [11:0] blk_sel;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [11:0] granted_block;
        logic [31:0] pub_addr;
        logic [15:0] first_port;
        logic [15:0] last_port;
        logic [12:0] busy_blocks;
        logic [12:0] blocks_quarantined;
        logic        free_available;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_DIV,
        S_ALLOC_MUL,
        S_REL_CHK,
        S_TICK_RD,
        S_TICK_CHK,
        S_REB_MUL,
        S_REB_FILL,
        S_REB_CLR,
        S_OUT
    } t_be_state;

endpackage

[rtl/nat_port_block_allocator_core.sv]
// Port block allocator for one carrier-grade NAT pool: top level over npba_pkg, npba_cmd_queue
// and npba_exec. Allocate pops the free list and splits the block id in a serial division;
// release moves an in-use block into quarantine; tick moves expired quarantined blocks back
// to the free list; rebuild clears the whole in-use map, then fills the free list. One request
// runs at a time; the next is taken only once the result has been accepted.
// Synchronous active-low reset empties both lists and restores defaults; rebuild clears the map.
module nat_port_block_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [11:0] i_blk_sel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [11:0] o_granted_block,
    output logic [31:0] o_pub_addr,
    output logic [15:0] o_first_port,
    output logic [15:0] o_last_port,
    output logic [12:0] o_busy_blocks,
    output logic [12:0] o_blocks_quarantined,
    output logic        o_free_available,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import npba_pkg::*;

    t_cmd    cmd_in, cmd_q;
    logic    q_valid, q_take;
    t_result res;

    // The front queue holds requests so the input can run ahead of the executor.
    assign cmd_in.op      = t_op'(i_operation);
    assign cmd_in.blk_sel = i_blk_sel;

    npba_cmd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_cmd(cmd_in),
        .o_valid(q_valid), .i_take(q_take), .o_cmd(cmd_q)
    );

    // The executor runs one request at a time and holds its result in a register.
    npba_exec u_exec (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(q_valid), .o_cmd_take(q_take), .i_cmd(cmd_q),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_res(res)
    );

    assign o_status             = res.status;
    assign o_granted_block      = res.granted_block;
    assign o_pub_addr           = res.pub_addr;
    assign o_first_port         = res.first_port;
    assign o_last_port          = res.last_port;
    assign o_busy_blocks        = res.busy_blocks;
    assign o_blocks_quarantined = res.blocks_quarantined;
    assign o_free_available     = res.free_available;
endmodule

[rtl/npba_cmd_queue.sv]
// Front part: a short command queue between the input channel and the executor.
// Depends on npba_pkg.
module npba_cmd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  npba_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    input  logic              i_take,
    output npba_pkg::t_cmd    o_cmd
);
    import npba_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_take;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[rtl/npba_exec.sv]
// Back part: sequencer that runs allocate, release, tick and rebuild against
// the free list, the quarantine list and the in-use map. Depends on npba_pkg.
module npba_exec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_take,
    input  npba_pkg::t_cmd      i_cmd,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output logic                o_valid,
    input  logic                i_stall,
    output npba_pkg::t_result   o_res
);
    import npba_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    // configuration registers
    logic [31:0] r_addr_start;
    logic [12:0] r_addr_count, r_bpa;
    logic [15:0] r_ppb, r_port_min, r_timeout;
    // latched geometry
    logic [31:0] r_g_addr;
    logic [12:0] r_g_bpa, r_g_ac;
    logic [15:0] r_g_ppb, r_g_pmin;
    logic [CW-1:0] r_pool;

    // memories
    logic [11:0] r_free_mem [MAX_BLOCKS];
    logic [43:0] r_quar_mem [MAX_BLOCKS];
    logic        r_inuse [MAX_BLOCKS];

    logic [AW-1:0] r_fh, r_ft, r_qh, r_qt;
    logic [CW-1:0] r_fc, r_qc;
    logic [31:0]   r_now;
    logic [12:0]   r_used;

    t_be_state r_st, n_st;
    logic [11:0] r_bid;
    t_result   r_res;
    logic      r_ovalid;

    // work registers
    logic [11:0] r_id;
    logic [11:0] r_quo, r_rem;
    logic [3:0]  r_dcnt;
    logic [12:0] r_p, r_a;
    logic [25:0] r_tot;
    logic [25:0] r_rowbase;
    logic [AW-1:0] r_clr;
    logic [11:0] r_frd;
    logic [43:0] r_qrd;
    logic        r_iurd;

    // memory write ports
    logic        f_we;
    logic [11:0] f_wd;
    logic        q_we;
    logic [43:0] q_wd;
    logic        iu_we;
    logic [AW-1:0] iu_wa;
    logic        iu_wd;

    logic [31:0] tdiff;
    logic [12:0] div_try;
    logic [12:0] div_rem_sh;
    logic        id_ok;

    always_ff @(posedge i_clk) begin
        if (f_we) r_free_mem[r_ft] <= f_wd;
        r_frd <= r_free_mem[r_fh];
    end
    always_ff @(posedge i_clk) begin
        if (q_we) r_quar_mem[r_qt] <= q_wd;
        r_qrd <= r_quar_mem[r_qh];
    end
    always_ff @(posedge i_clk) begin
        if (iu_we) r_inuse[iu_wa] <= iu_wd;
        r_iurd <= r_inuse[i_cmd.blk_sel[AW-1:0]];
    end

    assign tdiff      = r_now - r_qrd[31:0];
    assign div_rem_sh = {r_rem, r_id[11]};
    assign div_try    = div_rem_sh - r_g_bpa;
    assign id_ok      = ({{(26-12){1'b0}}, r_bid} < {{(26-CW){1'b0}}, r_pool});

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: begin
                if (o_cmd_take) begin
                    unique case (i_cmd.op)
                        OP_ALLOC:   n_st = S_ALLOC_RD;
                        OP_RELEASE: n_st = S_REL_CHK;
                        OP_TICK:    n_st = S_TICK_RD;
                        OP_REBUILD: n_st = S_REB_MUL;
                    endcase
                end
            end
            S_ALLOC_RD:  n_st = (r_fc == '0) ? S_OUT : S_ALLOC_DIV;
            S_ALLOC_DIV: n_st = (r_dcnt == 4'd11) ? S_ALLOC_MUL : S_ALLOC_DIV;
            S_ALLOC_MUL: n_st = S_OUT;
            S_REL_CHK:   n_st = S_OUT;
            S_TICK_RD:   n_st = S_TICK_CHK;
            S_TICK_CHK: begin
                if (r_qc != '0 && !tdiff[31]) n_st = S_TICK_RD;
                else n_st = S_OUT;
            end
            S_REB_MUL:   n_st = S_REB_CLR;
            S_REB_CLR:   n_st = (r_clr == AW'(MAX_BLOCKS - 1)) ? S_REB_FILL : S_REB_CLR;
            S_REB_FILL: begin
                if (r_g_bpa == '0 || r_p >= r_g_bpa
                        || {13'd0, r_p} >= {{(26-CW){1'b0}}, r_pool}) n_st = S_OUT;
            end
            S_OUT:       n_st = S_IDLE;
            default:     n_st = S_IDLE;
        endcase
    end

    assign o_cmd_take = (r_st == S_IDLE) && i_cmd_valid && !r_ovalid;
    assign o_valid    = r_ovalid;
    assign o_res      = r_res;

    always_comb begin
        f_we  = 1'b0;
        f_wd  = r_qrd[43:32];
        iu_we = 1'b0;
        iu_wa = r_clr;
        iu_wd = 1'b0;
        q_we  = (r_st == S_REL_CHK) && id_ok && r_iurd && (r_qc < MAXC);
        q_wd  = {r_bid, r_now + {16'd0, r_timeout}};
        if (r_st == S_TICK_CHK && r_qc != '0 && !tdiff[31] && r_fc < MAXC) f_we = 1'b1;
        if (r_st == S_REB_FILL && r_g_bpa != '0 && r_p < r_g_bpa
                && r_rowbase < {{(26-CW){1'b0}}, r_pool} && r_a < r_g_ac) begin
            f_we = 1'b1;
            f_wd = r_rowbase[11:0];
        end
        // One in-use map write a cycle: clear pass, grant, or release.
        if (r_st == S_REB_CLR) iu_we = 1'b1;
        if (r_st == S_ALLOC_RD && r_fc != '0) begin
            iu_we = 1'b1;
            iu_wa = r_frd[AW-1:0];
            iu_wd = 1'b1;
        end
        if (r_st == S_REL_CHK && id_ok && r_iurd) begin
            iu_we = 1'b1;
            iu_wa = r_bid[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_start <= '0; r_addr_count <= 13'd1; r_bpa <= 13'd1;
            r_ppb <= 16'd1; r_port_min <= 16'd1024; r_timeout <= 16'd60;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ADDR_START: r_addr_start <= i_cfg_data;
                CFG_ADDR_COUNT: r_addr_count <= i_cfg_data[12:0];
                CFG_BPA:        r_bpa        <= i_cfg_data[12:0];
                CFG_PPB:        r_ppb        <= i_cfg_data[15:0];
                CFG_PORT_MIN:   r_port_min   <= i_cfg_data[15:0];
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ovalid <= 1'b0;
            r_fh <= '0; r_ft <= '0; r_fc <= '0;
            r_qh <= '0; r_qt <= '0; r_qc <= '0;
            r_now <= '0; r_used <= '0; r_pool <= '0;
            r_g_bpa <= '0; r_g_ac <= '0; r_g_addr <= '0; r_g_ppb <= '0; r_g_pmin <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == S_OUT) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_bid <= i_cmd.blk_sel;
                        r_res <= '0;
                        if (i_cmd.op == OP_TICK) r_now <= r_now + 32'd1;
                        if (i_cmd.op == OP_REBUILD) begin
                            r_g_addr <= r_addr_start; r_g_bpa <= r_bpa;
                            r_g_ac <= r_addr_count;
                            r_g_ppb <= r_ppb; r_g_pmin <= r_port_min;
                            r_tot <= 26'(r_addr_count) * 26'(r_bpa);
                        end
                    end
                end
                S_ALLOC_RD: begin
                    if (r_fc == '0) r_res.status <= ST_NO_FREE;
                    else begin
                        r_id <= r_frd; r_quo <= '0; r_rem <= '0; r_dcnt <= '0;
                        r_fh <= (r_fh == AW'(MAX_BLOCKS - 1)) ? '0 : r_fh + AW'(1);
                        r_fc <= r_fc - CW'(1);
                        r_used <= r_used + 13'd1;
                        r_res.granted_block <= r_frd;
                    end
                end
                S_ALLOC_DIV: begin
                    // restoring division, one quotient bit a cycle
                    r_id <= {r_id[10:0], 1'b0};
                    if (r_g_bpa != '0 && !div_try[12] && div_rem_sh >= r_g_bpa) begin
                        r_rem <= div_try[11:0];
                        r_quo <= {r_quo[10:0], 1'b1};
                    end else begin
                        r_rem <= div_rem_sh[11:0];
                        r_quo <= {r_quo[10:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 4'd1;
                end
                S_ALLOC_MUL: begin
                    if (r_g_bpa != '0) begin
                        r_res.pub_addr   <= r_g_addr + {20'd0, r_quo};
                        r_res.first_port <= r_g_pmin + 16'(r_g_ppb * r_rem);
                        r_res.last_port  <= r_g_pmin + 16'(r_g_ppb * r_rem)
                                            + r_g_ppb - 16'd1;
                    end else begin
                        r_res.pub_addr   <= r_g_addr;
                        r_res.first_port <= r_g_pmin;
                        r_res.last_port  <= r_g_pmin + r_g_ppb - 16'd1;
                    end
                end
                S_REL_CHK: begin
                    if (!id_ok) r_res.status <= ST_RANGE;
                    else if (!r_iurd) r_res.status <= ST_NOT_USED;
                    else begin
                        if (r_used != '0) r_used <= r_used - 13'd1;
                        if (q_we) begin
                            r_qt <= (r_qt == AW'(MAX_BLOCKS - 1)) ? '0 : r_qt + AW'(1);
                            r_qc <= r_qc + CW'(1);
                        end
                    end
                end
                S_TICK_RD: ;
                S_TICK_CHK: begin
                    if (r_qc != '0 && !tdiff[31]) begin
                        if (f_we) begin
                            r_ft <= (r_ft == AW'(MAX_BLOCKS - 1)) ? '0 : r_ft + AW'(1);
                            r_fc <= r_fc + CW'(1);
                        end
                        r_qh <= (r_qh == AW'(MAX_BLOCKS - 1)) ? '0 : r_qh + AW'(1);
                        r_qc <= r_qc - CW'(1);
                    end
                end
                S_REB_MUL: begin
                    r_pool <= (r_g_ac == '0 || r_g_bpa == '0) ? '0 :
                              (r_tot > 26'(MAX_BLOCKS)) ? MAXC : CW'(r_tot);
                    r_fh <= '0; r_ft <= '0; r_fc <= '0;
                    r_qh <= '0; r_qt <= '0; r_qc <= '0;
                    r_used <= '0; r_clr <= '0;
                end
                S_REB_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    r_p <= '0; r_a <= '0; r_rowbase <= '0;
                end
                S_REB_FILL: begin
                    if (f_we) begin
                        r_ft <= (r_ft == AW'(MAX_BLOCKS - 1)) ? '0 : r_ft + AW'(1);
                        r_fc <= r_fc + CW'(1);
                    end
                    if (r_a + 13'd1 >= r_g_ac
                            || r_rowbase + {13'd0, r_g_bpa} >= {{(26-CW){1'b0}}, r_pool}) begin
                        r_a <= '0;
                        r_p <= r_p + 13'd1;
                        r_rowbase <= {13'd0, r_p} + 26'd1;
                    end else begin
                        r_a <= r_a + 13'd1;
                        r_rowbase <= r_rowbase + {13'd0, r_g_bpa};
                    end
                end
                S_OUT: begin
                    r_res.busy_blocks <= r_used;
                    r_res.blocks_quarantined <= 13'(r_qc);
                    r_res.free_available <= (r_fc != '0);
                end
                default: ;
            endcase
        end
    end
endmodule
